[design/ucs_pkg.sv]
// ----------------------------------------------------------------------------
// ucs_pkg: shared types and constants for the UTF-8 CJK space separator
//
// Holds the configuration record, the character record that travels from
// the decoder front end to the output back end, and the register indexes.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int CpW      = 21;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] SpaceByte = 8'h20;

  localparam logic [CfgIdxW-1:0] RegRangeALow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRangeAHigh = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRangeBLow  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRangeBHigh = CfgIdxW'(3);

  localparam logic [CpW-1:0] RangeALowRst  = 21'h004E00;
  localparam logic [CpW-1:0] RangeAHighRst = 21'h009FFF;
  localparam logic [CpW-1:0] RangeBLowRst  = 21'h003400;
  localparam logic [CpW-1:0] RangeBHighRst = 21'h004DBF;

  typedef struct packed {
    logic [CpW-1:0] a_low;
    logic [CpW-1:0] a_high;
    logic [CpW-1:0] b_low;
    logic [CpW-1:0] b_high;
  } cfg_t;

  // One decoded character or one error report.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            space;
    logic            last;
    logic            err;
  } rec_t;

endpackage

[design/ucs_front.sv]
// ----------------------------------------------------------------------------
// ucs_front: UTF-8 decoder and classifier
// Accepts one byte per cycle while the record queue has room, checks lead
// and continuation bytes, builds the code point, classifies it against both
// CJK ranges and decides whether a space goes in front. A complete character
// or an error becomes one record.
// ----------------------------------------------------------------------------
module ucs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ucs_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          full_i,
  output logic          push_o,
  output ucs_pkg::rec_t rec_o
);
  import ucs_pkg::*;

  logic [2:0]     exp_len_q, exp_len_d;
  logic [2:0]     seen_q, seen_d;
  logic [CpW-1:0] cp_q, cp_d;
  logic           plain_q, plain_d;
  logic           nonempty_q, nonempty_d;
  logic           lastsp_q, lastsp_d;
  logic           err_q, err_d;
  logic [7:0]     pend_q [3];

  logic           accept;
  logic           pend_we;
  logic           clear;
  logic [2:0]     len_c;
  logic [CpW-1:0] cp_c;
  logic           bad;
  logic [2:0]     rem;
  logic [CpW-1:0] cont_bits;
  logic           cjk;
  logic [7:0]     first_byte;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == SpaceByte) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    rem = exp_len_q - seen_q - 3'd1;
    case (rem)
      3'd0:    cont_bits = CpW'(in_byte_i[5:0]);
      3'd1:    cont_bits = CpW'(in_byte_i[5:0]) << 6;
      default: cont_bits = CpW'(in_byte_i[5:0]) << 12;
    endcase
  end

  always_comb begin
    bad   = 1'b0;
    len_c = exp_len_q;
    cp_c  = cp_q | cont_bits;
    if (seen_q == 3'd0) begin
      if (!in_byte_i[7]) begin
        len_c = 3'd1;
        cp_c  = CpW'(in_byte_i);
      end else if (in_byte_i[7:5] == 3'b110) begin
        len_c = 3'd2;
        cp_c  = {10'd0, in_byte_i[4:0], 6'd0};
      end else if (in_byte_i[7:4] == 4'b1110) begin
        len_c = 3'd3;
        cp_c  = {5'd0, in_byte_i[3:0], 12'd0};
      end else if (in_byte_i[7:3] == 5'b11110) begin
        len_c = 3'd4;
        cp_c  = {in_byte_i[2:0], 18'd0};
      end else begin
        bad = 1'b1;
      end
    end else begin
      bad = (in_byte_i[7:6] != 2'b10);
    end
  end

  assign cjk = ((cp_c >= cfg_i.a_low) && (cp_c <= cfg_i.a_high)) ||
               ((cp_c >= cfg_i.b_low) && (cp_c <= cfg_i.b_high));
  assign first_byte = (len_c == 3'd1) ? in_byte_i : pend_q[0];

  always_comb begin
    exp_len_d  = exp_len_q;
    seen_d     = seen_q;
    cp_d       = cp_q;
    plain_d    = plain_q;
    nonempty_d = nonempty_q;
    lastsp_d   = lastsp_q;
    err_d      = err_q;
    push_o     = 1'b0;
    pend_we    = 1'b0;
    clear      = 1'b0;
    rec_o      = '0;
    rec_o.len  = 3'd1;
    rec_o.last = in_last_i;
    rec_o.err  = 1'b1;
    if (accept) begin
      if (err_q) begin
        push_o = in_last_i;
        clear  = in_last_i;
      end else if (bad) begin
        push_o = 1'b1;
        clear  = in_last_i;
        err_d  = 1'b1;
      end else if ((seen_q + 3'd1) < len_c) begin
        if (in_last_i) begin
          push_o = 1'b1;
          clear  = 1'b1;
        end else begin
          pend_we   = 1'b1;
          seen_d    = seen_q + 3'd1;
          exp_len_d = len_c;
          cp_d      = cp_c;
        end
      end else begin
        push_o         = 1'b1;
        rec_o.err      = 1'b0;
        rec_o.len      = len_c;
        rec_o.bytes[0] = first_byte;
        rec_o.bytes[1] = (len_c == 3'd2) ? in_byte_i : pend_q[1];
        rec_o.bytes[2] = (len_c == 3'd3) ? in_byte_i : pend_q[2];
        rec_o.bytes[3] = in_byte_i;
        if (cjk) begin
          rec_o.space = nonempty_q && !lastsp_q;
        end else begin
          rec_o.space = !plain_q && nonempty_q && !is_ws(first_byte);
        end
        plain_d    = !cjk;
        nonempty_d = 1'b1;
        lastsp_d   = is_ws(in_byte_i);
        seen_d     = 3'd0;
        exp_len_d  = 3'd0;
        cp_d       = '0;
        clear      = in_last_i;
      end
    end
    if (clear) begin
      exp_len_d  = 3'd0;
      seen_d     = 3'd0;
      cp_d       = '0;
      plain_d    = 1'b0;
      nonempty_d = 1'b0;
      lastsp_d   = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q  <= 3'd0;
      seen_q     <= 3'd0;
      cp_q       <= '0;
      plain_q    <= 1'b0;
      nonempty_q <= 1'b0;
      lastsp_q   <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      exp_len_q  <= exp_len_d;
      seen_q     <= seen_d;
      cp_q       <= cp_d;
      plain_q    <= plain_d;
      nonempty_q <= nonempty_d;
      lastsp_q   <= lastsp_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[seen_q[1:0]] <= in_byte_i;
    end
  end

endmodule

[design/ucs_queue.sv]
// ----------------------------------------------------------------------------
// ucs_queue: character record queue
//
// A small first-in first-out queue of character records that lets the
// decoder and the output stage stall independently.
// ----------------------------------------------------------------------------
module ucs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ucs_pkg::rec_t rec_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output ucs_pkg::rec_t head_o
);
  import ucs_pkg::*;

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule

[design/ucs_back.sv]
// ----------------------------------------------------------------------------
// ucs_back: output byte sequencer
//
// Walks the record at the head of the queue one byte per cycle, the inserted
// space first, and holds each byte in an output register until it is taken.
// ----------------------------------------------------------------------------
module ucs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ucs_pkg::rec_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic          m_tlast_o,
  output logic [1:0]    m_tuser_o
);
  import ucs_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] data_q;
  logic       tlast_q;
  logic       strend_q;
  logic       inv_q;

  logic       load;
  logic [2:0] total;
  logic       last_beat;
  logic [2:0] k;
  logic [7:0] sel_byte;

  assign total     = head_i.len + {2'd0, head_i.space};
  assign last_beat = (idx_q == (total - 3'd1));
  assign load      = !empty_i && (!ovalid_q || m_tready_i);
  assign pop_o     = load && last_beat;
  assign k         = idx_q - {2'd0, head_i.space};
  assign sel_byte  = (head_i.space && (idx_q == 3'd0)) ? SpaceByte : head_i.bytes[k[1:0]];

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q && !m_tready_i;
    if (load) begin
      ovalid_d = 1'b1;
      idx_d    = last_beat ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= sel_byte;
      tlast_q  <= last_beat;
      strend_q <= last_beat && head_i.last;
      inv_q    <= head_i.err;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = tlast_q;
  assign m_tuser_o  = {inv_q, strend_q};

`ifndef SYNTHESIS
  a_idx_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < total))
    else $error("byte index runs past the head record");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && inv_q) |-> (tlast_q && (data_q == 8'h00)))
    else $error("error result is not a single zero byte");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && strend_q) |-> tlast_q)
    else $error("string end flagged on a byte that does not close its record");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ovalid_q)
    else $error("loaded byte did not reach the output register");
`endif

endmodule

[design/utf8_cjk_space_separator.sv]
// ----------------------------------------------------------------------------
// utf8_cjk_space_separator: UTF-8 decoder that spaces out CJK characters
//
// Decodes a UTF-8 byte stream and re-emits it with spaces so that every CJK
// character stands alone; malformed or truncated input yields an error flag.
// ----------------------------------------------------------------------------
// An input byte is accepted every cycle while the four-entry character queue
// has room. The output stage emits one byte per cycle while its bytes are
// taken, so a character of n bytes leaves as n output bytes, or n + 1 when a
// space goes in front. A completed character passes through the character
// queue and then the output register before it appears at the output. An
// error report is a single result with out_byte zero; after it, bytes are
// dropped until the last byte of the string, which gives one more error
// result marked as the end of the string. Range registers are written
// through the config channel; the user must write them only while the block
// is idle, as the block itself does not enforce it. A range whose low
// exceeds its high is empty.
module utf8_cjk_space_separator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // in_byte[7:0]
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // out_byte[7:0]
  output logic                            m_axis_tlast,
  output logic [1:0]                      m_axis_tuser,  // string_end[0], invalid[1]
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ucs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ucs_pkg::CfgDataW-1:0]    cfg_data_i
);
  import ucs_pkg::*;

  cfg_t cfg_q, cfg_d;
  rec_t rec;
  rec_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRangeALow:  cfg_d.a_low  = cfg_data_i[CpW-1:0];
        RegRangeAHigh: cfg_d.a_high = cfg_data_i[CpW-1:0];
        RegRangeBLow:  cfg_d.b_low  = cfg_data_i[CpW-1:0];
        RegRangeBHigh: cfg_d.b_high = cfg_data_i[CpW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_low  <= RangeALowRst;
      cfg_q.a_high <= RangeAHighRst;
      cfg_q.b_low  <= RangeBLowRst;
      cfg_q.b_high <= RangeBHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ucs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (rec)
  );

  ucs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  ucs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_cjk_space_separator
//
// Feeds UTF-8 strings byte by byte into the block and predicts each output
// byte in step with every accepted input request. Directed strings cover
// range edges, the longest code point and every error kind the block flags.
// Random strings run under several range settings, with random gaps and
// stalls on both streams, and under a long hold-off on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ucs_pkg::*;

  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       invalid;
  } spaced_byte_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;  // in_byte[7:0]
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;           // out_byte[7:0]
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;           // string_end[0], invalid[1]
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  cfg_t           range_cfg = '{RangeALowRst, RangeAHighRst, RangeBLowRst, RangeBHighRst};
  logic [7:0]     held_bytes [3];
  int             need_len = 0;
  int             got_len = 0;
  logic [CpW-1:0] cp_acc = '0;
  bit             plain_run = 1'b0;
  bit             text_started = 1'b0;
  bit             last_was_ws = 1'b0;
  bit             err_latched = 1'b0;

  spaced_byte_t spaced_text_q [$];
  spaced_byte_t want;
  spaced_byte_t seen;
  logic [7:0]   text_q [$];
  int           mismatches = 0;
  int           items_counted = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           stall_cycles = 0;
  int           cycle_count = 0;

  utf8_cjk_space_separator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
      if (spaced_text_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected nothing, got byte=%h last=%b end=%b invalid=%b",
                 $time, seen.out_byte, seen.run_last, seen.string_end, seen.invalid);
      end else begin
        want = spaced_text_q.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display("%0t: expected byte=%h last=%b end=%b invalid=%b, got byte=%h last=%b end=%b invalid=%b",
                   $time, want.out_byte, want.run_last, want.string_end, want.invalid,
                   seen.out_byte, seen.run_last, seen.string_end, seen.invalid);
        end
      end
    end
    if (stall_cycles > 0) begin
      m_axis_tready <= 1'b0;
      stall_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic bit is_ws(logic [7:0] b);
    return b == SpaceByte || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic add_expected(input spaced_byte_t r);
    spaced_text_q.insert(spaced_text_q.size(), r);
  endtask

  task automatic add_text_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic restart_string();
    need_len     = 0;
    got_len      = 0;
    cp_acc       = '0;
    plain_run    = 1'b0;
    text_started = 1'b0;
    last_was_ws  = 1'b0;
    err_latched  = 1'b0;
  endtask

  task automatic flag_bad_utf8(input logic last);
    add_expected('{8'h00, 1'b1, last, 1'b1});
    if (last) restart_string();
    else err_latched = 1'b1;
  endtask

  task automatic space_cjk_byte(input logic [7:0] b, input logic last);
    logic [7:0] chars [4];
    bit         cjk;
    bit         put_space;
    if (err_latched) begin
      if (last) flag_bad_utf8(1'b1);
      return;
    end
    if (got_len == 0) begin
      if (b[7] == 1'b0) begin
        need_len = 1;
        cp_acc   = CpW'(b);
      end else if (b[7:5] == 3'b110) begin
        need_len = 2;
        cp_acc   = CpW'(b[4:0]) << 6;
      end else if (b[7:4] == 4'b1110) begin
        need_len = 3;
        cp_acc   = CpW'(b[3:0]) << 12;
      end else if (b[7:3] == 5'b11110) begin
        need_len = 4;
        cp_acc   = CpW'(b[2:0]) << 18;
      end else begin
        flag_bad_utf8(last);
        return;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        flag_bad_utf8(last);
        return;
      end
      cp_acc = cp_acc | (CpW'(b[5:0]) << (6 * (need_len - 1 - got_len)));
    end
    if (got_len + 1 < need_len) begin
      if (last) begin
        flag_bad_utf8(1'b1);
        return;
      end
      held_bytes[got_len] = b;
      got_len++;
      return;
    end
    for (int i = 0; i < need_len - 1; i++) chars[i] = held_bytes[i];
    chars[need_len-1] = b;
    cjk = (cp_acc >= range_cfg.a_low && cp_acc <= range_cfg.a_high) ||
          (cp_acc >= range_cfg.b_low && cp_acc <= range_cfg.b_high);
    if (cjk) begin
      put_space = text_started && !last_was_ws;
      plain_run = 1'b0;
    end else begin
      put_space = !plain_run && text_started && !is_ws(chars[0]);
      plain_run = 1'b1;
    end
    if (put_space) add_expected('{SpaceByte, 1'b0, 1'b0, 1'b0});
    for (int i = 0; i < need_len; i++) begin
      add_expected('{chars[i], i == need_len - 1, last && i == need_len - 1, 1'b0});
    end
    text_started = 1'b1;
    last_was_ws  = is_ws(chars[need_len-1]);
    got_len      = 0;
    need_len     = 0;
    cp_acc       = '0;
    if (last) restart_string();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_counted++;
    space_cjk_byte(b, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (spaced_text_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_ranges(input cfg_t c);
    logic [CfgIdxW-1:0] reg_idx [4];
    logic [CpW-1:0]     reg_val [4];
    reg_idx = '{RegRangeALow, RegRangeAHigh, RegRangeBLow, RegRangeBHigh};
    reg_val = '{c.a_low, c.a_high, c.b_low, c.b_high};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i  <= CfgDataW'(reg_val[i]);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    range_cfg = c;
  endtask

  task automatic push_cp(input logic [CpW-1:0] cp, input int len);
    case (len)
      1: add_text_byte({1'b0, cp[6:0]});
      2: begin
        add_text_byte({3'b110, cp[10:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_text_byte({4'b1110, cp[15:12]});
        add_text_byte({2'b10, cp[11:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_text_byte({5'b11110, cp[20:18]});
        add_text_byte({2'b10, cp[17:12]});
        add_text_byte({2'b10, cp[11:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [CpW-1:0] pick_cjk_cp();
    bit a_ok;
    bit b_ok;
    a_ok = range_cfg.a_low <= range_cfg.a_high;
    b_ok = range_cfg.b_low <= range_cfg.b_high;
    if (a_ok && (!b_ok || $urandom_range(1)))
      return CpW'($urandom_range(range_cfg.a_high, range_cfg.a_low));
    if (b_ok) return CpW'($urandom_range(range_cfg.b_high, range_cfg.b_low));
    return CpW'($urandom_range(21'h1FFFFF));
  endfunction

  function automatic logic [CpW-1:0] range_edge_cp();
    logic [CpW-1:0] edges [8];
    edges = '{range_cfg.a_low - 1'b1, range_cfg.a_low, range_cfg.a_high,
              range_cfg.a_high + 1'b1, range_cfg.b_low - 1'b1, range_cfg.b_low,
              range_cfg.b_high, range_cfg.b_high + 1'b1};
    return edges[$urandom_range(7)];
  endfunction

  task automatic build_string(input int n_chars);
    logic [CpW-1:0] cp;
    int             len;
    int             pos;
    text_q.delete();
    repeat (n_chars) begin
      case ($urandom_range(9))
        0, 1: cp = CpW'($urandom_range(8'h7E, 8'h21));
        2: begin
          pos = $urandom_range(5);
          cp  = (pos == 5) ? CpW'(SpaceByte) : CpW'(8'h09 + pos);
        end
        3: cp = CpW'($urandom_range(8'h7F));
        4: cp = CpW'($urandom_range(12'h7FF, 8'h80));
        5, 6: cp = pick_cjk_cp();
        7: cp = CpW'($urandom_range(16'hFFFF));
        8: cp = CpW'($urandom_range(21'h1FFFFF));
        default: cp = range_edge_cp();
      endcase
      len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
      if (len < 4 && $urandom_range(19) == 0) len++;
      push_cp(cp, len);
    end
    if ($urandom_range(99) < 20) begin
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(2))
        0: text_q[pos] = 8'($urandom_range(255));
        1: text_q.insert(pos, 8'($urandom_range(255)));
        default: if (text_q.size() > 1) void'(text_q.pop_back());
      endcase
    end
  endtask

  task automatic run_strings(input int n_items);
    int first;
    first = items_counted;
    while (items_counted - first < n_items) begin
      build_string($urandom_range(8, 1));
      send_text();
    end
  endtask

  task automatic test_directed_cases();
    text_q = '{8'h41, 8'hE4, 8'hB8, 8'h80, 8'h09, 8'hE4, 8'hB6, 8'hBF,
               8'hE9, 8'hBF, 8'hBF, 8'h00};
    send_text();
    text_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'h80, 8'h41, 8'h0A};
    send_text();
    text_q = '{8'hE9, 8'h41};
    send_text();
    text_q = '{8'hFF};
    send_text();
    text_q = '{8'hE9, 8'hBF};
    send_text();
    text_q = '{8'hC0, 8'h80, 8'h20, 8'h7F};
    send_text();
    wait_drained();
  endtask

  task automatic test_range_registers();
    cfg_t settings [6];
    settings = '{
      '{21'h000000, 21'h000000, 21'h1FFFFF, 21'h000000},
      '{21'h000000, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF},
      '{21'h1FFFFF, 21'h000000, 21'h1FFFFF, 21'h000000},
      '{21'h000041, 21'h00005A, 21'h1FFFFF, 21'h1FFFFF},
      '{21'h000000, 21'h000000, 21'h000000, 21'h000000},
      '{RangeALowRst, RangeAHighRst, RangeBLowRst, RangeBHighRst}
    };
    settings[4].a_low  = CpW'($urandom_range(21'h1FFFFF));
    settings[4].a_high = CpW'($urandom_range(21'h1FFFFF, settings[4].a_low));
    settings[4].b_low  = CpW'($urandom_range(21'h00FFFF));
    settings[4].b_high = CpW'($urandom_range(21'h01FFFF, settings[4].b_low));
    foreach (settings[k]) begin
      write_ranges(settings[k]);
      run_strings(12);
      wait_drained();
    end
  endtask

  task automatic test_flow_control();
    int src_modes [4];
    int sink_modes [4];
    src_modes  = '{0, 48, 0, 8};
    sink_modes = '{0, 0, 48, 8};
    foreach (src_modes[m]) begin
      src_idle_pct   = src_modes[m];
      sink_stall_pct = sink_modes[m];
      run_strings(52);
      wait_drained();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    stall_cycles = 300;
    run_strings(25);
    wait_drained();
    run_strings(20);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    restart_string();
    test_directed_cases();
    test_range_registers();
    test_flow_control();
    test_output_backpressure();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && spaced_text_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ucs_pkg.sv
design/ucs_front.sv
design/ucs_queue.sv
design/ucs_back.sv
design/utf8_cjk_space_separator.sv
test/testbench.sv
